// ===== hw/rtl/ev_charger_pilot_state_machine_assert.svh =====
// assertion macros for the control pilot rtl
// no dependencies; included by the module that carries assertions, evcp_fsm
`ifndef EV_CHARGER_PILOT_STATE_MACHINE_ASSERT_SVH
`define EV_CHARGER_PILOT_STATE_MACHINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EVCP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("evcp assertion failed");

// next-cycle implication, disabled during reset
`define EVCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("evcp assertion failed");

`endif

// ===== hw/rtl/evcp_pkg.sv =====
// types, constants and helpers for the control pilot state machine
// no dependencies; used by the interface and module rtl files
`default_nettype none

package evcp_pkg;

  // current limits and pause length
  localparam int unsigned MIN_AMPS    = 6;
  localparam int unsigned MAX_AMPS    = 63;
  localparam int unsigned PAUSE_TICKS = 5;

  // field widths
  localparam int LEVEL_W      = 3;
  localparam int STATE_CODE_W = 3;
  localparam int AMPS_W       = 8;
  localparam int REQ_W        = 12;
  localparam int PAUSE_W      = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // divide by ten through a reciprocal, exact for values below 16384
  localparam int DIV10_MUL_W = 13;
  localparam int DIV10_SHIFT = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(6554);
  localparam int DIV10_PROD_W = REQ_W + DIV10_MUL_W;
  localparam int DIV10_Q_W    = DIV10_PROD_W - DIV10_SHIFT;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_CURRENT = CFG_IDX_W'(1);
  localparam logic [AMPS_W-1:0]    MAX_CURRENT_RESET = AMPS_W'(32);
  localparam logic [REQ_W-1:0]     REQ_CURRENT_RESET = REQ_W'(320);

  // sensed pilot levels
  localparam logic [LEVEL_W-1:0] LVL_12V = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LVL_9V  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LVL_6V  = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] LVL_3V  = LEVEL_W'(3);
  localparam logic [LEVEL_W-1:0] LVL_1V  = LEVEL_W'(4);

  // reported state codes
  localparam logic [STATE_CODE_W-1:0] CODE_A = STATE_CODE_W'(0);
  localparam logic [STATE_CODE_W-1:0] CODE_B = STATE_CODE_W'(1);
  localparam logic [STATE_CODE_W-1:0] CODE_C = STATE_CODE_W'(2);
  localparam logic [STATE_CODE_W-1:0] CODE_D = STATE_CODE_W'(3);
  localparam logic [STATE_CODE_W-1:0] CODE_E = STATE_CODE_W'(4);

  // charger state, one-hot
  typedef enum logic [4:0] {
    ST_A = 5'b00001,
    ST_B = 5'b00010,
    ST_C = 5'b00100,
    ST_D = 5'b01000,
    ST_E = 5'b10000
  } charger_state_t;

  // pilot drive
  typedef enum logic [1:0] {
    MODE_HIGH = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_PWM  = 2'd2
  } pilot_mode_t;

  // one result item
  typedef struct packed {
    logic [STATE_CODE_W-1:0] charge_state;
    pilot_mode_t             pilot_mode;
    logic [AMPS_W-1:0]       pilot_amps;
    logic                    relay_closed;
    logic                    pausing;
  } result_t;

  // one-hot state to reported code
  function automatic logic [STATE_CODE_W-1:0] state_code(input charger_state_t s);
    logic [STATE_CODE_W-1:0] c;
    unique case (s)
      ST_A:    c = CODE_A;
      ST_B:    c = CODE_B;
      ST_C:    c = CODE_C;
      ST_D:    c = CODE_D;
      default: c = CODE_E;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/evcp_if.sv =====
// valid/ready channels of the control pilot block: tick, result, config write
// depends on evcp_pkg
`default_nettype none

// tick request carrying the sensed pilot level
interface evcp_pilot_if import evcp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pilot_level;
  modport source(output valid, pilot_level, input ready);
  modport sink(input valid, pilot_level, output ready);
endinterface

// result request for one tick
interface evcp_result_if import evcp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATE_CODE_W-1:0] charge_state;
  logic [1:0]              pilot_mode;
  logic [AMPS_W-1:0]       pilot_amps;
  logic                    relay_closed;
  logic                    pausing;
  modport source(output valid, charge_state, pilot_mode, pilot_amps, relay_closed,
                 pausing, input ready);
  modport sink(input valid, charge_state, pilot_mode, pilot_amps, relay_closed,
               pausing, output ready);
endinterface

// configuration register write
interface evcp_cfg_if import evcp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ev_charger_pilot_state_machine.sv =====
// Control pilot state machine for an EV charger. Each tick request carries the sensed
// pilot level and yields exactly one result request. A tick is held in an input register
// and, once the output register is free or being drained, handled by a single pass of
// next-state logic over the charger state and pause countdown, whose result lands in an
// output register: a new tick is taken every cycle while the result side is not stalled,
// and its result is presented from the output register once the held tick advances.
// The update of the state registers on each advance sets that rate.
// Configuration writes are always taken and apply to ticks handled after the write.
// depends on evcp_pkg, evcp_if, evcp_cfg and evcp_fsm
`default_nettype none

module ev_charger_pilot_state_machine import evcp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  evcp_pilot_if.sink   pilot,
  evcp_result_if.source result,
  evcp_cfg_if.sink     cfg
);

  logic               in_full;
  logic [LEVEL_W-1:0] in_level;
  logic               advance;
  logic               out_valid;
  result_t            out_res;
  result_t            res;
  logic [AMPS_W-1:0]  eff_amps;

  // move the held tick on when the output register is free or being drained
  assign advance     = in_full && (!out_valid || result.ready);
  assign pilot.ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (pilot.valid && pilot.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pilot.valid && pilot.ready) begin
      in_level <= pilot.pilot_level;
    end
  end

  evcp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .eff_amps (eff_amps)
  );

  evcp_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .level    (in_level),
    .eff_amps (eff_amps),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.charge_state = out_res.charge_state;
  assign result.pilot_mode   = out_res.pilot_mode;
  assign result.pilot_amps   = out_res.pilot_amps;
  assign result.relay_closed = out_res.relay_closed;
  assign result.pausing      = out_res.pausing;

endmodule

`default_nettype wire

// ===== hw/rtl/evcp_cfg.sv =====
// configuration registers and effective charging current in whole amps
// depends on evcp_pkg and evcp_if
`default_nettype none

module evcp_cfg import evcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  evcp_cfg_if.sink         cfg,
  output logic [AMPS_W-1:0] eff_amps
);

  logic [AMPS_W-1:0]       amps_limit;
  logic [REQ_W-1:0]        req_current;
  logic [AMPS_W-1:0]       max_sat;
  logic [DIV10_PROD_W-1:0] req_prod;
  logic [DIV10_Q_W-1:0]    req_amps;
  logic [DIV10_Q_W-1:0]    req_raised;
  logic [DIV10_Q_W-1:0]    req_capped;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      amps_limit  <= MAX_CURRENT_RESET;
      req_current <= REQ_CURRENT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_MAX_CURRENT) begin
        amps_limit <= cfg.data[AMPS_W-1:0];
      end else if (cfg.index == CFG_REQ_CURRENT) begin
        req_current <= cfg.data[REQ_W-1:0];
      end
    end
  end

  // saturate the maximum, lower bound first
  always_comb begin
    max_sat = amps_limit;
    if (max_sat < AMPS_W'(MIN_AMPS)) max_sat = AMPS_W'(MIN_AMPS);
    if (max_sat > AMPS_W'(MAX_AMPS)) max_sat = AMPS_W'(MAX_AMPS);
  end

  // bounds are whole amps, so clamping after the divide gives the same floor
  assign req_prod = DIV10_PROD_W'(req_current) * DIV10_PROD_W'(DIV10_MUL);
  assign req_amps = req_prod[DIV10_PROD_W-1:DIV10_SHIFT];

  always_comb begin
    req_raised = req_amps;
    if (req_raised < DIV10_Q_W'(MIN_AMPS)) req_raised = DIV10_Q_W'(MIN_AMPS);
    req_capped = req_raised;
    if (req_capped > DIV10_Q_W'(max_sat)) req_capped = DIV10_Q_W'(max_sat);
  end

  assign eff_amps = req_capped[AMPS_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/evcp_fsm.sv =====
// charger state and pause countdown with next-state and result logic
// depends on evcp_pkg and the assertion macro header
`default_nettype none
`include "ev_charger_pilot_state_machine_assert.svh"

module evcp_fsm import evcp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic [AMPS_W-1:0]  eff_amps,
  output result_t                 res
);

  charger_state_t       state;
  charger_state_t       state_next;
  logic [PAUSE_W-1:0]   pause_left;
  logic                 pause_busy;
  logic                 load_pause;
  logic                 pwm_active;

  assign pause_busy = (pause_left != '0);
  assign load_pause = advance && !pause_busy && (state_next == ST_E);
  assign pwm_active = (res.pilot_mode == MODE_PWM) && !res.pausing;

  // legal steps, undecoded levels keep the state, everything else goes to E
  always_comb begin
    state_next = state;
    unique case (level)
      LVL_12V: state_next = ST_A;
      LVL_9V: begin
        if (state == ST_B) state_next = ST_B;
        else if (state == ST_A || state == ST_C || state == ST_D) state_next = ST_B;
        else state_next = ST_E;
      end
      LVL_6V: begin
        if (state == ST_C) state_next = ST_C;
        else if (state == ST_B || state == ST_D) state_next = ST_C;
        else state_next = ST_E;
      end
      LVL_3V: begin
        if (state == ST_D) state_next = ST_D;
        else if (state == ST_B || state == ST_C) state_next = ST_D;
        else state_next = ST_E;
      end
      LVL_1V:  state_next = ST_E;
      default: state_next = state;
    endcase
  end

  // state and countdown update, one tick per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_A;
      pause_left <= '0;
    end else if (advance) begin
      if (pause_busy) begin
        pause_left <= pause_left - PAUSE_W'(1);
      end else begin
        state      <= state_next;
        pause_left <= (state_next == ST_E) ? PAUSE_W'(PAUSE_TICKS) : '0;
      end
    end
  end

  // result of the tick
  always_comb begin
    res              = '0;
    res.pilot_mode   = MODE_HIGH;
    if (pause_busy) begin
      res.charge_state = state_code(state);
      res.pausing      = 1'b1;
      res.pilot_mode   = (pause_left == PAUSE_W'(1)) ? MODE_HIGH : MODE_LOW;
    end else begin
      res.charge_state = state_code(state_next);
      unique case (state_next)
        ST_A: res.pilot_mode = MODE_HIGH;
        ST_B: begin
          res.pilot_mode = MODE_PWM;
          res.pilot_amps = eff_amps;
        end
        ST_C, ST_D: begin
          res.pilot_mode   = MODE_PWM;
          res.pilot_amps   = eff_amps;
          res.relay_closed = 1'b1;
        end
        default: res.pilot_mode = MODE_LOW;
      endcase
    end
  end

  // checks
  `EVCP_ASSERT_IMPLIES(a_pause_only_in_e, clk, rst, pause_left != '0, state == ST_E)
  `EVCP_ASSERT_NEXT(a_e_loads_pause, clk, rst, load_pause, pause_left == PAUSE_W'(PAUSE_TICKS))
  `EVCP_ASSERT_NEXT(a_pause_keeps_state, clk, rst, advance && pause_busy, state == $past(state))
  `EVCP_ASSERT_IMPLIES(a_relay_needs_pwm, clk, rst, res.relay_closed, pwm_active)

endmodule

`default_nettype wire

// ===== test/tb_ev_charger_pilot_state_machine.sv =====
// testbench for the control pilot state machine: directed and random pilot ticks,
// checked field by field against a behavioural model of the charger states
// depends on evcp_pkg, evcp_if and the ev_charger_pilot_state_machine rtl
`timescale 1ns / 1ps

module tb_ev_charger_pilot_state_machine;
  import evcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned FIXED_PHASES = 8;
  localparam int unsigned STEADY_PHASE = 4;
  localparam int unsigned PHASE_TICKS = 105;
  localparam int unsigned IDLE_PCT    = 12;
  localparam int unsigned DRAIN_WAIT  = 20;

  // levels the block leaves undecoded
  localparam logic [LEVEL_W-1:0] LVL_UNDEF_LO = LVL_1V + 1'b1;
  localparam logic [LEVEL_W-1:0] LVL_UNDEF_HI = '1;

  logic clk = 1'b0;
  logic rst;

  evcp_pilot_if  pilot_ch ();
  evcp_result_if result_ch ();
  evcp_cfg_if    cfg_ch ();

  ev_charger_pilot_state_machine uut (
    .clk   (clk),
    .rst   (rst),
    .pilot (pilot_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  // model state and register copies
  logic [STATE_CODE_W-1:0] pilot_state;
  logic [PAUSE_W-1:0]      pause_left;
  logic [AMPS_W-1:0]       max_amps_cfg;
  logic [REQ_W-1:0]        req_tenths_cfg;

  logic [LEVEL_W-1:0] pending_levels[$];
  result_t            due_results[$];
  result_t            oldest_due;
  int unsigned        levels_queued = 0;
  int unsigned        levels_taken  = 0;
  int unsigned        fails = 0;
  int unsigned        cycle_count = 0;
  logic               tick_taken;
  logic               steady;

  // effective current: requested tenths clamped between the minimum and the saturated maximum
  function automatic logic [AMPS_W-1:0] charge_amps();
    int unsigned ceiling;
    int unsigned tenths;
    ceiling = max_amps_cfg;
    if (ceiling < MIN_AMPS) ceiling = MIN_AMPS;
    if (ceiling > MAX_AMPS) ceiling = MAX_AMPS;
    tenths = req_tenths_cfg;
    if (tenths < MIN_AMPS * 10) tenths = MIN_AMPS * 10;
    if (tenths > ceiling * 10) tenths = ceiling * 10;
    return AMPS_W'(tenths / 10);
  endfunction

  // charger state after a sensed level, illegal steps go to E
  function automatic logic [STATE_CODE_W-1:0] next_code(input logic [STATE_CODE_W-1:0] s,
                                                        input logic [LEVEL_W-1:0] level);
    logic [STATE_CODE_W-1:0] n;
    n = s;
    case (level)
      LVL_12V: n = CODE_A;
      LVL_9V: begin
        if (s != CODE_B) n = (s == CODE_A || s == CODE_C || s == CODE_D) ? CODE_B : CODE_E;
      end
      LVL_6V: begin
        if (s != CODE_C) n = (s == CODE_B || s == CODE_D) ? CODE_C : CODE_E;
      end
      LVL_3V: begin
        if (s != CODE_D) n = (s == CODE_B || s == CODE_C) ? CODE_D : CODE_E;
      end
      LVL_1V: n = CODE_E;
      default: n = s;
    endcase
    return n;
  endfunction

  // expected result of one accepted tick
  task automatic predict_tick(input logic [LEVEL_W-1:0] level);
    result_t r;
    r = '0;
    r.pilot_mode = MODE_HIGH;
    if (pause_left != 0) begin
      pause_left = pause_left - 1'b1;
      r.pausing = 1'b1;
      r.pilot_mode = (pause_left == 0) ? MODE_HIGH : MODE_LOW;
    end else begin
      pilot_state = next_code(pilot_state, level);
      case (pilot_state)
        CODE_A: r.pilot_mode = MODE_HIGH;
        CODE_B: begin
          r.pilot_mode = MODE_PWM;
          r.pilot_amps = charge_amps();
        end
        CODE_C, CODE_D: begin
          r.pilot_mode = MODE_PWM;
          r.pilot_amps = charge_amps();
          r.relay_closed = 1'b1;
        end
        default: begin
          r.pilot_mode = MODE_LOW;
          pause_left = PAUSE_W'(PAUSE_TICKS);
        end
      endcase
    end
    r.charge_state = pilot_state;
    due_results.push_back(r);
  endtask

  // tick driver, new request only once the previous one has gone
  always @(negedge clk) begin
    if (rst) begin
      pilot_ch.valid <= 1'b0;
    end else if (!pilot_ch.valid || tick_taken) begin
      if (pending_levels.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        pilot_ch.valid <= 1'b1;
        pilot_ch.pilot_level <= pending_levels.pop_front();
      end else begin
        pilot_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // monitor: check results first, then predict the tick taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: state %0d mode %0d amps %0d relay %0b pausing %0b",
                     result_ch.charge_state, result_ch.pilot_mode, result_ch.pilot_amps,
                     result_ch.relay_closed, result_ch.pausing);
          fails++;
        end else begin
          oldest_due = due_results.pop_front();
          if (result_ch.charge_state !== oldest_due.charge_state ||
              result_ch.pilot_mode !== oldest_due.pilot_mode ||
              result_ch.pilot_amps !== oldest_due.pilot_amps ||
              result_ch.relay_closed !== oldest_due.relay_closed ||
              result_ch.pausing !== oldest_due.pausing) begin
            if (fails < 10)
              $display("mismatch: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                       oldest_due.charge_state, oldest_due.pilot_mode, oldest_due.pilot_amps,
                       oldest_due.relay_closed, oldest_due.pausing,
                       result_ch.charge_state, result_ch.pilot_mode, result_ch.pilot_amps,
                       result_ch.relay_closed, result_ch.pausing);
            fails++;
          end
        end
      end
      if (pilot_ch.valid && pilot_ch.ready) begin
        predict_tick(pilot_ch.pilot_level);
        levels_taken <= levels_taken + 1;
        tick_taken <= 1'b1;
      end else begin
        tick_taken <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_ev_charger_pilot_state_machine NOT OK");
      $finish;
    end
  end

  task automatic push_level(input logic [LEVEL_W-1:0] level);
    pending_levels.push_back(level);
    levels_queued++;
  endtask

  // ticks landing in the pause countdown, any level
  task automatic push_pause_tail();
    repeat (PAUSE_TICKS) push_level(LEVEL_W'($urandom_range(0, 7)));
  endtask

  // mostly plug-in sessions with random states, some noise and faults
  task automatic queue_random_ticks(input int unsigned count);
    int unsigned start;
    int unsigned run_len;
    int unsigned pick;
    start = levels_queued;
    while (levels_queued - start < count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_level(LEVEL_W'($urandom_range(0, 7)));
      end else begin
        push_level(LVL_12V);
        push_level(LVL_9V);
        run_len = $urandom_range(2, 20);
        repeat (run_len) begin
          if ($urandom_range(99) < 8)
            push_level(LEVEL_W'($urandom_range(LVL_UNDEF_LO, LVL_UNDEF_HI)));
          else
            push_level(LEVEL_W'($urandom_range(LVL_9V, LVL_3V)));
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
          push_level(LVL_12V);
        end else if (pick < 80) begin
          // fault from a charging state
          push_level(LVL_1V);
          push_pause_tail();
        end else if (pick < 90) begin
          // illegal step out of A
          push_level(LVL_12V);
          push_level(LEVEL_W'($urandom_range(LVL_6V, LVL_3V)));
          push_pause_tail();
        end else begin
          // fault, then a level that keeps E and reloads the pause
          push_level(LVL_1V);
          push_pause_tail();
          push_level(LEVEL_W'($urandom_range(LVL_9V, LVL_UNDEF_HI)));
          push_pause_tail();
        end
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_MAX_CURRENT) max_amps_cfg = value[AMPS_W-1:0];
    else if (idx == CFG_REQ_CURRENT) req_tenths_cfg = value[REQ_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // block idle: every tick taken and every result back
  task automatic wait_drained();
    while (levels_taken != levels_queued || due_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [LEVEL_W-1:0] opening[24];
    int unsigned max_list[FIXED_PHASES];
    int unsigned req_list[FIXED_PHASES];
    opening = '{LVL_12V, LVL_9V, LVL_6V, LVL_3V, LVL_9V, LVL_3V, LVL_6V, LVL_9V,
                LVL_UNDEF_LO, LVL_12V, LVL_UNDEF_HI, LVL_3V,
                LVL_1V, LVL_12V, LVL_9V, LVL_UNDEF_HI, LVL_6V,
                LVL_9V,
                LVL_12V, LVL_12V, LVL_12V, LVL_12V, LVL_12V,
                LVL_12V};
    max_list = '{0, 255, 6, 63, 64, 5, 255, 40};
    req_list = '{0, 4095, 60, 630, 2550, 59, 0, 2049};

    rst = 1'b1;
    steady = 1'b0;
    pilot_ch.valid = 1'b0;
    pilot_ch.pilot_level = LVL_12V;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_CURRENT;
    cfg_ch.data = '0;
    pilot_state = CODE_A;
    pause_left = '0;
    max_amps_cfg = MAX_CURRENT_RESET;
    req_tenths_cfg = REQ_CURRENT_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // walk through legal steps, undecoded levels, faults and pauses
    foreach (opening[i]) push_level(opening[i]);
    wait_drained();

    // register settings: extremes first, then random
    for (int unsigned ph = 1; ph < PHASES; ph++) begin
      if (ph <= FIXED_PHASES) begin
        cfg_write(CFG_MAX_CURRENT, CFG_DATA_W'(max_list[ph-1]));
        cfg_write(CFG_REQ_CURRENT, CFG_DATA_W'(req_list[ph-1]));
      end else begin
        cfg_write(CFG_MAX_CURRENT, CFG_DATA_W'($urandom_range(0, 255)));
        cfg_write(CFG_REQ_CURRENT, CFG_DATA_W'($urandom_range(0, 2550)));
      end
      steady = (ph == STEADY_PHASE);
      queue_random_ticks(PHASE_TICKS);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_results.size() != 0) fails++;
    if (fails == 0)
      $display("tb_ev_charger_pilot_state_machine OK");
    else
      $display("tb_ev_charger_pilot_state_machine NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/evcp_pkg.sv
hw/rtl/evcp_if.sv
hw/rtl/evcp_cfg.sv
hw/rtl/evcp_fsm.sv
hw/rtl/ev_charger_pilot_state_machine.sv
test/tb_ev_charger_pilot_state_machine.sv
